FILE: src/opm_pkg.sv
// Shared types and constants of the oil-paint filter.
package opm_pkg;
  localparam int unsigned MaxWidth   = 512;
  localparam int unsigned MaxHeight  = 512;
  localparam int unsigned MaxRadius  = 7;
  localparam int unsigned NumBins    = 256;
  localparam int unsigned ColW       = 9;
  localparam int unsigned RowW       = 9;
  localparam int unsigned AddrW      = ColW + RowW;
  localparam int unsigned PixW       = 24;
  localparam int unsigned CntW       = 8;
  localparam int unsigned SumW       = 16;
  localparam int unsigned HistW      = CntW + 3 * SumW;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 48;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam logic OpStore   = 1'b0;
  localparam logic OpRequest = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StClear, StWinRd, StWinAcc, StScan, StScanLast, StDiv, StOut
  } state_e;
endpackage

FILE: src/oil_paint_mode_filter_top.sv
// Oil-paint filter top level: frame store, histogram memory and sequencer.
// Operation: a store writes the pixel into the frame store; a request clears the 256-bin
// histogram, walks the clipped window pixel by pixel, scans the bins for the fullest one,
// then runs three 16-step divisions for the mean red, green and blue of that bin.
// One request at a time: new input items are taken only in the idle state.
// Reset (rst_ni, async) clears control state, sets width 512, height 512, radius 5.
module oil_paint_mode_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: col[8:0], row[17:9], red_in[25:18], green_in[33:26], blue_in[41:34], zeros
  input  logic [opm_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: col_out[8:0], row_out[17:9], red_out[25:18], green_out[33:26],
  // blue_out[41:34], zeros
  output logic [opm_pkg::OutDataW-1:0] m_axis_tdata
);
  import opm_pkg::*;

  // configuration registers
  logic [9:0] width_q, height_q;
  logic [2:0] radius_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 10'd512;
      height_q <= 10'd512;
      radius_q <= 3'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [10:0] eff_w, eff_h;
  assign eff_w = (width_q > 10'(MaxWidth)) ? 11'(MaxWidth) : {1'b0, width_q};
  assign eff_h = (height_q > 10'(MaxHeight)) ? 11'(MaxHeight) : {1'b0, height_q};

  // input fields
  logic [8:0] in_col, in_row;
  logic [23:0] in_pix;
  assign in_col = s_axis_tdata[8:0];
  assign in_row = s_axis_tdata[17:9];
  assign in_pix = {s_axis_tdata[25:18], s_axis_tdata[33:26], s_axis_tdata[41:34]};
  logic in_image;
  assign in_image = ({2'b0, in_col} < eff_w) && ({2'b0, in_row} < eff_h);

  state_e state_q, state_d;
  logic [8:0] col_q, col_d, row_q, row_d, x_q, x_d, y_q, y_d;
  logic [8:0] c1_q, c1_d, r0_q, r0_d, r1_q, r1_d;
  logic [7:0] k_q, k_d, best_bin_q, best_bin_d, best_q, best_d;
  logic [1:0] ch_q, ch_d;
  logic [15:0] sr_q, sr_d, sg_q, sg_d, sb_q, sb_d;
  logic [7:0] ro_q, ro_d, go_q, go_d, bo_q, bo_d;
  logic       div_start;
  logic [15:0] div_num;
  logic       div_done;
  logic [7:0] div_quot;
  logic       rd_pending_q, rd_pending_d;

  // frame store
  logic fs_we;
  logic [AddrW-1:0] fs_raddr;
  logic [PixW-1:0] fs_rdata;
  opm_ram #(.Width(PixW), .Depth(MaxWidth * MaxHeight)) u_frame (
    .clk_i, .we_i(fs_we), .waddr_i({in_row, in_col}), .wdata_i(in_pix),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

  // histogram memory: {count, sum_r, sum_g, sum_b}
  logic h_we;
  logic [7:0] h_waddr, h_raddr;
  logic [HistW-1:0] h_wdata, h_rdata;
  opm_ram #(.Width(HistW), .Depth(NumBins)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  opm_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(best_q), .done_o(div_done), .quot_o(div_quot)
  );

  // window pixel bin: sum/3 via reciprocal (sum < 766)
  logic [9:0] px_sum;
  logic [19:0] px_mul;
  logic [7:0] px_bin;
  assign px_sum = 10'(fs_rdata[23:16]) + 10'(fs_rdata[15:8]) + 10'(fs_rdata[7:0]);
  assign px_mul = px_sum * 10'd683;
  assign px_bin = px_mul[18:11];

  // pixel registered alongside its bin for the read-modify-write
  logic [23:0] pix_q;
  logic [7:0]  bin_q;
  always_ff @(posedge clk_i) begin
    pix_q <= fs_rdata;
    bin_q <= px_bin;
  end

  logic [9:0] cr_lo, rr_lo, c_hi, r_hi;
  assign cr_lo = {1'b0, in_col} - {7'b0, radius_q};
  assign rr_lo = {1'b0, in_row} - {7'b0, radius_q};
  assign c_hi  = {1'b0, in_col} + {7'b0, radius_q};
  assign r_hi  = {1'b0, in_row} + {7'b0, radius_q};

  always_comb begin
    state_d = state_q;
    col_d = col_q; row_d = row_q; x_d = x_q; y_d = y_q;
    c1_d = c1_q; r0_d = r0_q; r1_d = r1_q;
    k_d = k_q; best_bin_d = best_bin_q; best_d = best_q; ch_d = ch_q;
    sr_d = sr_q; sg_d = sg_q; sb_d = sb_q;
    ro_d = ro_q; go_d = go_q; bo_d = bo_q;
    rd_pending_d = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    fs_we = 1'b0;
    fs_raddr = {y_q, x_q};
    h_we = 1'b0; h_waddr = k_q; h_wdata = '0; h_raddr = k_q;
    div_start = 1'b0;
    div_num = sr_q;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && in_image) begin
          if (s_axis_tuser == OpStore) begin
            fs_we = 1'b1;
          end else begin
            col_d = in_col; row_d = in_row;
            x_d = cr_lo[9] ? 9'd0 : cr_lo[8:0];
            r0_d = rr_lo[9] ? 9'd0 : rr_lo[8:0];
            y_d = rr_lo[9] ? 9'd0 : rr_lo[8:0];
            c1_d = ({1'b0, c_hi} < eff_w - 11'd1) ? c_hi[8:0] : 9'(eff_w - 11'd1);
            r1_d = ({1'b0, r_hi} < eff_h - 11'd1) ? r_hi[8:0] : 9'(eff_h - 11'd1);
            k_d = '0;
            state_d = StClear;
          end
        end
      end
      StClear: begin
        h_we = 1'b1;
        k_d = k_q + 8'd1;
        if (k_q == 8'hFF) state_d = StWinRd;
      end
      StWinRd: begin
        // frame read issued; bin known next cycle
        rd_pending_d = 1'b1;
        state_d = StWinAcc;
      end
      StWinAcc: begin
        // histogram read of the bin just computed
        h_raddr = px_bin;
        if (!rd_pending_q) begin
          h_we = 1'b1;
          h_waddr = bin_q;
          h_wdata = {h_rdata[55:48] + 8'd1,
                     h_rdata[47:32] + 16'(pix_q[23:16]),
                     h_rdata[31:16] + 16'(pix_q[15:8]),
                     h_rdata[15:0] + 16'(pix_q[7:0])};
          if (y_q == r1_q) begin
            y_d = r0_q;
            if (x_q == c1_q) begin
              k_d = '0; best_d = '0; best_bin_d = '0;
              state_d = StScan;
            end else begin
              x_d = x_q + 9'd1;
              state_d = StWinRd;
            end
          end else begin
            y_d = y_q + 9'd1;
            state_d = StWinRd;
          end
        end else begin
          rd_pending_d = 1'b0;
        end
      end
      StScan: begin
        // read k, compare the previous entry
        h_raddr = k_q;
        if (k_q != 8'd0 && h_rdata[55:48] > best_q) begin
          best_d = h_rdata[55:48];
          best_bin_d = k_q - 8'd1;
        end
        k_d = k_q + 8'd1;
        if (k_q == 8'hFF) state_d = StScanLast;
      end
      StScanLast: begin
        h_raddr = best_bin_q;
        if (h_rdata[55:48] > best_q) begin
          best_d = h_rdata[55:48];
          best_bin_d = 8'hFF;
          h_raddr = 8'hFF;
        end
        ch_d = 2'd3;
        state_d = StDiv;
      end
      StDiv: begin
        if (ch_q == 2'd3) begin
          sr_d = h_rdata[47:32]; sg_d = h_rdata[31:16]; sb_d = h_rdata[15:0];
          div_start = 1'b1; div_num = h_rdata[47:32];
          ch_d = 2'd0;
        end else if (div_done) begin
          unique case (ch_q)
            2'd0: begin ro_d = div_quot; div_start = 1'b1; div_num = sg_q; end
            2'd1: begin go_d = div_quot; div_start = 1'b1; div_num = sb_q; end
            default: begin bo_d = div_quot; state_d = StOut; end
          endcase
          ch_d = ch_q + 2'd1;
        end
      end
      StOut: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rd_pending_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_pending_q <= rd_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d; row_q <= row_d; x_q <= x_d; y_q <= y_d;
    c1_q <= c1_d; r0_q <= r0_d; r1_q <= r1_d;
    k_q <= k_d; best_bin_q <= best_bin_d; best_q <= best_d; ch_q <= ch_d;
    sr_q <= sr_d; sg_q <= sg_d; sb_q <= sb_d;
    ro_q <= ro_d; go_q <= go_d; bo_q <= bo_d;
  end

  assign m_axis_tdata = {6'b0, bo_q, go_q, ro_q, row_q, col_q};
endmodule

FILE: src/opm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module opm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/opm_divider.sv
// Restoring divider: 16-bit dividend by 8-bit divisor, one bit a cycle.
module opm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        done_o,
  output logic [7:0]  quot_o
);
  logic [15:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  div_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [9:0]  trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[15]} - {2'b00, div_q};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[9]) begin
        rem_d = trial[8:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[7:0], quo_q[15]};
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) div_q <= divisor_i;
  end

  // quotient valid once the iterations are over
  assign done_o = !busy_q;
  assign quot_o = quo_q[7:0];
endmodule

FILE: tb/tb_top.sv
// Testbench of the oil-paint filter: random store and request traffic, checked by a scoreboard.

// Scoreboard: predicts filtered pixels and checks the output stream in order.
class opm_scoreboard;
  logic [23:0] pix_mem [int];
  int unsigned img_w = 512, img_h = 512, win_rad = 5;
  logic [41:0] pending [$];
  int mismatches = 0;
  int checked = 0;

  function void set_reg(logic [1:0] idx, logic [9:0] val);
    if (idx == opm_pkg::RegWidth) img_w = val;
    else if (idx == opm_pkg::RegHeight) img_h = val;
    else if (idx == opm_pkg::RegRadius) win_rad = val[2:0];
  endfunction

  // Note an accepted input item; queue the filtered pixel for a request.
  function void note_input(logic op, logic [8:0] c, logic [8:0] r, logic [23:0] rgb);
    int unsigned w, h, c0, c1, r0, r1, bin, best, best_bin;
    int unsigned cnt [256];
    int unsigned sr [256], sg [256], sb [256];
    logic [23:0] px;
    w = (img_w > 512) ? 512 : img_w;
    h = (img_h > 512) ? 512 : img_h;
    if (c >= w || r >= h) return;
    if (op == opm_pkg::OpStore) begin
      pix_mem[r * 512 + c] = rgb;
      return;
    end
    for (int k = 0; k < 256; k++) begin
      cnt[k] = 0; sr[k] = 0; sg[k] = 0; sb[k] = 0;
    end
    c0 = (c > win_rad) ? c - win_rad : 0;
    r0 = (r > win_rad) ? r - win_rad : 0;
    c1 = (c + win_rad < w - 1) ? c + win_rad : w - 1;
    r1 = (r + win_rad < h - 1) ? r + win_rad : h - 1;
    for (int x = c0; x <= c1; x++)
      for (int y = r0; y <= r1; y++) begin
        px = pix_mem.exists(y * 512 + x) ? pix_mem[y * 512 + x] : 24'd0;
        bin = (px[23:16] + px[15:8] + px[7:0]) / 3;
        cnt[bin]++;
        sr[bin] += px[23:16]; sg[bin] += px[15:8]; sb[bin] += px[7:0];
      end
    best = 0; best_bin = 0;
    for (int k = 0; k < 256; k++)
      if (cnt[k] > best) begin
        best = cnt[k]; best_bin = k;
      end
    pending.push_back({8'(sb[best_bin] / best), 8'(sg[best_bin] / best),
                       8'(sr[best_bin] / best), r, c});
  endfunction

  function void check_result(logic [41:0] got);
    logic [41:0] exp_px;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_px = pending.pop_front();
    checked++;
    if (got !== exp_px) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: expected col %0d row %0d rgb %h/%h/%h, ",
                  "got col %0d row %0d rgb %h/%h/%h"},
                 exp_px[8:0], exp_px[17:9], exp_px[25:18], exp_px[33:26], exp_px[41:34],
                 got[8:0], got[17:9], got[25:18], got[33:26], got[41:34]);
    end
  endfunction
endclass

module tb_top;
  import opm_pkg::*;

  localparam int CycleLimit = 8000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [9:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  opm_scoreboard sb = new();
  int unsigned cycles = 0;
  bit  calm = 1'b0;       // no idling on either side
  int  n_items = 0, n_req = 0;
  // written pixels in the small test area, for well-formed requests
  bit  wr_map [16][16];

  oil_paint_mode_filter_top DUT (.*);

  always #2 clk_i = ~clk_i;

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output side: random stall, check accepted results
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[41:0]);
    m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Drive one input item; valid stays high into the next one unless an idle gap comes
  task automatic send_item(logic op, logic [8:0] c, logic [8:0] r, logic [23:0] rgb);
    if (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 31);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, rgb[7:0], rgb[15:8], rgb[23:16], r, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, c, r, rgb);
    n_items++;
    if (op == OpRequest) n_req++;
    if (op == OpStore && c < 16 && r < 16 && c < sb.img_w && r < sb.img_h) wr_map[c][r] = 1;
  endtask

  // Idle the block before a register write
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  // Fill a corner area of the test region with random pixels
  task automatic fill_area(int wmax, int hmax);
    for (int y = 0; y < hmax; y++)
      for (int x = 0; x < wmax; x++)
        send_item(OpStore, 9'(x), 9'(y), 24'($urandom()));
  endtask

  // Request only where the whole window has been written
  function automatic bit window_written(int c, int r);
    int rad, w, h;
    rad = sb.win_rad; w = sb.img_w; h = sb.img_h;
    for (int x = (c > rad ? c - rad : 0); x <= ((c + rad < w - 1) ? c + rad : w - 1); x++)
      for (int y = (r > rad ? r - rad : 0); y <= ((r + rad < h - 1) ? r + rad : h - 1); y++)
        if (x >= 16 || y >= 16 || !wr_map[x][y]) return 0;
    return 1;
  endfunction

  task automatic random_phase(int count);
    int c, r;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(15); r = $urandom_range(15);
      case ($urandom_range(9))
        0: begin
          // anywhere in the frame; requests only where they fall outside the image
          c = $urandom_range(511); r = $urandom_range(511);
          if (c >= sb.img_w || r >= sb.img_h)
            send_item(1'($urandom_range(1)), 9'(c), 9'(r), 24'($urandom()));
          else
            send_item(OpStore, 9'(c), 9'(r), 24'($urandom()));
        end
        1, 2, 3, 4, 5: send_item(OpStore, 9'(c), 9'(r), 24'($urandom()));
        default: begin
          if (window_written(c, r)) send_item(OpRequest, 9'(c), 9'(r), 24'($urandom()));
          else send_item(OpStore, 9'(c), 9'(r), 24'($urandom()));
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes of pixel values, edges of a tiny image, ignored items
    write_reg(RegWidth, 10'd4);
    write_reg(RegHeight, 10'd3);
    write_reg(RegRadius, 10'd0);
    send_item(OpStore, 0, 0, 24'hFFFFFF);
    send_item(OpStore, 3, 2, 24'h000000);
    send_item(OpStore, 4, 0, 24'h123456);      // column outside: ignored
    send_item(OpRequest, 0, 511, 24'h0);       // row outside: no result
    send_item(OpRequest, 0, 0, 24'hFFFFFF);
    send_item(OpRequest, 3, 2, 24'h0);
    drain();
    write_reg(RegRadius, 10'd7);
    fill_area(4, 3);
    send_item(OpRequest, 0, 0, 24'h0);
    send_item(OpRequest, 3, 2, 24'h0);
    send_item(OpStore, 1, 1, 24'hFF00FF);
    send_item(OpRequest, 1, 1, 24'h0);
    drain();
    // Oversized width saturates; zero height makes every item outside
    write_reg(RegWidth, 10'h3FF);
    write_reg(RegHeight, 10'd0);
    send_item(OpStore, 511, 0, 24'hABCDEF);
    send_item(OpRequest, 0, 0, 24'h0);
    drain();
    write_reg(RegHeight, 10'd512);
    send_item(OpStore, 511, 511, 24'hFFFFFF);
    send_item(OpStore, 510, 511, 24'h000000);
    send_item(OpStore, 511, 510, 24'h808080);
    send_item(OpStore, 510, 510, 24'h7F7F7F);
    write_reg(RegRadius, 10'd1);
    send_item(OpRequest, 511, 511, 24'h0);

    // Random phases over several geometries; corner area refilled each time
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      calm = (ph == 3);
      write_reg(RegWidth, (ph == 1) ? 10'd1 : (ph == 4) ? 10'd600 : 10'($urandom_range(16, 512)));
      write_reg(RegHeight, (ph == 2) ? 10'd1 : 10'($urandom_range(16, 1023)));
      write_reg(RegRadius, (ph == 0) ? 10'd0 : (ph == 5) ? 10'd7 : 10'($urandom_range(7)));
      foreach (wr_map[x, y]) wr_map[x][y] = 0;
      fill_area(12, 12);
      random_phase(46);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    $display("covered %0d input items, %0d requests, %0d results checked",
             n_items, n_req, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
